FILE: design/ndf_pkg.sv
// shared types and constants of the neighbor despeckle filter
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package ndf_pkg;

    localparam int PIX_W       = 8;
    localparam int ROWS_W      = 11;
    localparam int ROW_W       = 10;
    localparam int ROWS_MIN    = 2;
    localparam int ROWS_MAX    = 1024;
    localparam int ROWS_RESET  = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // floor(x / 6) == (x * RECIP6) >> RECIP6_SHIFT for x < 2048
    localparam int RECIP6       = 683;
    localparam int RECIP6_SHIFT = 12;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             filt;
        logic             has_up;
        logic             flush;
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/ndf_if.sv
// valid/ready stream interfaces for pixel input beats and filtered result beats
// depends on ndf_pkg
`default_nettype none

interface ndf_in_if;
    import ndf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface ndf_out_if;
    import ndf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: design/neighbor_despeckle_filter.sv
// top level of the neighbor despeckle filter: front end, command queue, back end
// depends on ndf_pkg, ndf_if, ndf_front, ndf_cmd_queue, ndf_back
//
// Streams a frame of LINE_WIDTH columns and frame_rows rows (clamped to 2..1024) in
// raster order and replaces every pixel that differs by more than one from any of its
// 4-neighbors with their mean, rounded half up; left and upper neighbors are already
// filtered values. Results trail the input by one row. A row-0 pixel is only written to
// the raw line memory; each later pixel is taken as the line memories are read, then
// filtered and written back. The last pixel of a frame starts a flush of the final row,
// a fetch and an exec state per column, and the flush's last beat carries frame_end.
// A two-entry queue buffers pixels meanwhile; filtering waits for a free output register.
// Write frame_rows only while the block is idle.
`default_nettype none

module neighbor_despeckle_filter #(
    parameter int LINE_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [ndf_pkg::ROWS_W-1:0] cfg_data,
    ndf_in_if.sink                          pixel_stream,
    ndf_out_if.source                       result_stream
);
    import ndf_pkg::*;

    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    ndf_front #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .pixel_stream (pixel_stream),
        .cmd          (front_cmd),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready)
    );

    ndf_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_cmd   (back_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    ndf_back #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (back_cmd),
        .cmd_valid     (back_valid),
        .cmd_ready     (back_ready),
        .result_stream (result_stream)
    );

endmodule

`default_nettype wire

FILE: design/ndf_front.sv
// front end: takes pixel beats, tracks raster position and frame_rows,
// and turns each beat into a command for the back end; depends on ndf_pkg, ndf_if
`default_nettype none

module ndf_front #(
    parameter int LINE_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [ndf_pkg::ROWS_W-1:0] cfg_data,
    ndf_in_if.sink                          pixel_stream,
    output ndf_pkg::cmd_t                   cmd,
    output logic                            cmd_valid,
    input  wire logic                       cmd_ready
);
    import ndf_pkg::*;

    localparam int COL_W = $clog2(LINE_WIDTH);

    logic [ROWS_W-1:0] rows_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  rows_m1;
    logic              last_col;
    logic              last_row;
    logic              accept;

    always_comb
    begin
        priority if (rows_reg < ROWS_W'(ROWS_MIN))
            rows_m1 = ROW_W'(ROWS_MIN - 1);
        else if (rows_reg > ROWS_W'(ROWS_MAX))
            rows_m1 = ROW_W'(ROWS_MAX - 1);
        else
            rows_m1 = ROW_W'(rows_reg - ROWS_W'(1));
    end

    assign last_col = (col_reg == COL_W'(LINE_WIDTH - 1));
    assign last_row = (row_reg >= rows_m1);

    assign pixel_stream.ready = cmd_ready;
    assign cmd_valid          = pixel_stream.valid;
    assign accept             = pixel_stream.valid && cmd_ready;

    assign cmd.pixel  = pixel_stream.pixel_in;
    assign cmd.filt   = (row_reg != '0);
    assign cmd.has_up = (row_reg > ROW_W'(1));
    assign cmd.flush  = last_col && last_row;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_W'(ROWS_RESET);
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                rows_reg <= cfg_data;
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/ndf_cmd_queue.sv
// two-entry command queue between the front and back ends
// depends on ndf_pkg
`default_nettype none

module ndf_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ndf_pkg::cmd_t in_cmd,
    input  wire logic          in_valid,
    output logic               in_ready,
    output ndf_pkg::cmd_t      out_cmd,
    output logic               out_valid,
    input  wire logic          out_ready
);
    import ndf_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

`default_nettype wire

FILE: design/ndf_back.sv
// back end: line memories, four-neighbor outlier test and mean replacement,
// final-row flush and output register; depends on ndf_pkg, ndf_if
`default_nettype none

module ndf_back #(
    parameter int LINE_WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ndf_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    ndf_out_if.source          result_stream
);
    import ndf_pkg::*;

    localparam int COL_W = $clog2(LINE_WIDTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             flushing_reg, flushing_next;
    cmd_t             cmd_reg;
    logic [PIX_W-1:0] left_reg;

    logic [PIX_W-1:0] raw_mem  [LINE_WIDTH];
    logic [PIX_W-1:0] filt_mem [LINE_WIDTH];
    logic [PIX_W-1:0] center_q, right_q, up_q;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_end_reg;

    logic             last_col;
    logic [COL_W-1:0] right_addr;
    logic             out_free;
    logic             take_cmd;
    logic             exec_fire;

    logic             raw_we;
    logic [PIX_W-1:0] raw_wd;

    logic             hl, hr, hu, hd;
    logic [PIX_W-1:0] dl, dr, du, dd;
    logic             flag;
    logic [9:0]       sum;
    logic [2:0]       cnt;
    logic [10:0]      half_sum;
    logic [10:0]      quad_sum;
    logic [10:0]      six_num;
    logic [20:0]      six_prod;
    logic [PIX_W-1:0] mean;
    logic [PIX_W-1:0] result;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    assign last_col   = (col_reg == COL_W'(LINE_WIDTH - 1));
    assign right_addr = last_col ? '0 : col_reg + COL_W'(1);
    assign out_free   = !out_valid_reg || result_stream.ready;
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign take_cmd   = cmd_valid && cmd_ready;
    assign exec_fire  = (state_reg == ST_EXEC) && out_free;

    // neighbor presence and outlier test
    always_comb
    begin
        hl = (col_reg != '0);
        hr = !last_col;
        hu = flushing_reg || cmd_reg.has_up;
        hd = !flushing_reg;
        dl = abs_diff(center_q, left_reg);
        dr = abs_diff(center_q, right_q);
        du = abs_diff(center_q, up_q);
        dd = abs_diff(center_q, cmd_reg.pixel);
        flag = (hl && dl > PIX_W'(1)) || (hr && dr > PIX_W'(1))
            || (hu && du > PIX_W'(1)) || (hd && dd > PIX_W'(1));
        sum = (hl ? 10'(left_reg) : 10'd0) + (hr ? 10'(right_q) : 10'd0)
            + (hu ? 10'(up_q) : 10'd0) + (hd ? 10'(cmd_reg.pixel) : 10'd0);
        cnt = 3'(hl) + 3'(hr) + 3'(hu) + 3'(hd);
    end

    // mean rounded half up
    always_comb
    begin
        half_sum = 11'(sum) + 11'd1;
        quad_sum = 11'(sum) + 11'd2;
        six_num  = {sum, 1'b0} + 11'd3;
        six_prod = 21'(six_num) * 21'(RECIP6);
        unique case (cnt)
            3'd1:    mean = sum[PIX_W-1:0];
            3'd2:    mean = half_sum[PIX_W:1];
            3'd3:    mean = six_prod[RECIP6_SHIFT +: PIX_W];
            3'd4:    mean = quad_sum[PIX_W+1:2];
            default: mean = center_q;
        endcase
        result = flag ? mean : center_q;
    end

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        flushing_next = flushing_reg;
        raw_we        = 1'b0;
        raw_wd        = cmd_reg.pixel;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_cmd)
                begin
                    if (cmd.filt)
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        raw_we   = 1'b1;
                        raw_wd   = cmd.pixel;
                        col_next = last_col ? '0 : col_reg + COL_W'(1);
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    raw_we = !flushing_reg;
                    if (flushing_reg)
                    begin
                        if (last_col)
                        begin
                            flushing_next = 1'b0;
                            col_next      = '0;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            col_next   = col_reg + COL_W'(1);
                            state_next = ST_FETCH;
                        end
                    end
                    else if (cmd_reg.flush)
                    begin
                        flushing_next = 1'b1;
                        col_next      = '0;
                        state_next    = ST_FETCH;
                    end
                    else
                    begin
                        col_next   = last_col ? '0 : col_reg + COL_W'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            flushing_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            flushing_reg <= flushing_next;
            if (exec_fire)
                out_valid_reg <= 1'b1;
            else if (result_stream.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
            cmd_reg <= cmd;
        if (exec_fire)
        begin
            left_reg      <= result;
            out_pixel_reg <= result;
            out_end_reg   <= flushing_reg && last_col;
        end
    end

    // line memories
    always_ff @(posedge clk)
    begin
        if (raw_we)
            raw_mem[col_reg] <= raw_wd;
        center_q <= raw_mem[col_reg];
        right_q  <= raw_mem[right_addr];
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
            filt_mem[col_reg] <= result;
        up_q <= filt_mem[col_reg];
    end

    assign result_stream.valid     = out_valid_reg;
    assign result_stream.pixel_out = out_pixel_reg;
    assign result_stream.frame_end = out_end_reg;

endmodule

`default_nettype wire
